>>> hw/rtl/dnlt_pkg.sv
// Shared types and constants for the day and night light tracker.
`timescale 1ns / 1ps

package dnlt_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MORNING_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EVENING_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EVENING_HOLD_MS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MORNING_HOLD_MS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STARTUP_WAIT_MS = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STUCK_LIMIT_MS  = 3'd5;

   // Register reset values
   localparam longint unsigned MORNING_LEVEL_RST   = 64'd10;
   localparam longint unsigned EVENING_LEVEL_RST   = 64'd5;
   localparam longint unsigned EVENING_HOLD_MS_RST = 64'd900000;
   localparam longint unsigned MORNING_HOLD_MS_RST = 64'd900000;
   localparam longint unsigned STARTUP_WAIT_MS_RST = 64'd1000;
   localparam longint unsigned STUCK_LIMIT_MS_RST  = 64'd72000000;

   localparam int unsigned PHASE_BITS = 3;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_START = 3'd0,
      PH_DAY   = 3'd1,
      PH_EVE   = 3'd2,
      PH_NWORK = 3'd3,
      PH_NIGHT = 3'd4,
      PH_MORN  = 3'd5,
      PH_DWORK = 3'd6,
      PH_FAIL  = 3'd7
   } phase_type;

endpackage

>>> hw/rtl/day_night_light_tracker.sv
// Day and night light tracker: input register, phase logic and result register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_sensor_value, req_now_ms
//  rsp     | out       | rsp_valid / rsp_stall | rsp_phase_now, rsp_night_work_pulse,
//          |           |                       | rsp_day_work_pulse
//  csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// One item per cycle while the result is not stalled; each item goes through the
// input register, then the phase update and result register. The phase and timer
// origin are updated in the cycle an item moves from the input register to the
// result register. Synchronous reset returns the phase to start, the timer origin
// to zero and the registers to their defaults. A stalled result holds both stages;
// req_stall rises only when both stages are full and the result is stalled.
`timescale 1ns / 1ps

module day_night_light_tracker
   import dnlt_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 10,
   parameter int unsigned TIME_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_sensor_value,
   input  logic [TIME_BITS-1:0]    req_now_ms,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PHASE_BITS-1:0]   rsp_phase_now,
   output logic                    rsp_night_work_pulse,
   output logic                    rsp_day_work_pulse,

   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]    csr_wdata
);

   // Configuration registers
   logic [SAMPLE_BITS-1:0] morning_level_ff;
   logic [SAMPLE_BITS-1:0] evening_level_ff;
   logic [TIME_BITS-1:0]   evening_hold_ff;
   logic [TIME_BITS-1:0]   morning_hold_ff;
   logic [TIME_BITS-1:0]   startup_wait_ff;
   logic [TIME_BITS-1:0]   stuck_limit_ff;

   // Input stage
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] sensor_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // Tracker state
   phase_type              phase_ff;
   phase_type              phase_in;
   logic [TIME_BITS-1:0]   origin_ff;
   logic [TIME_BITS-1:0]   origin_in;

   // Result stage
   logic                   rsp_valid_ff;
   phase_type              rsp_phase_ff;
   logic                   rsp_nw_ff;
   logic                   rsp_dw_ff;

   logic                   advance;
   logic                   step;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   nw_pulse;
   logic                   dw_pulse;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Wrapping difference
   assign elapsed = now_ff - origin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         morning_level_ff <= SAMPLE_BITS'(MORNING_LEVEL_RST);
         evening_level_ff <= SAMPLE_BITS'(EVENING_LEVEL_RST);
         evening_hold_ff  <= TIME_BITS'(EVENING_HOLD_MS_RST);
         morning_hold_ff  <= TIME_BITS'(MORNING_HOLD_MS_RST);
         startup_wait_ff  <= TIME_BITS'(STARTUP_WAIT_MS_RST);
         stuck_limit_ff   <= TIME_BITS'(STUCK_LIMIT_MS_RST);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MORNING_LEVEL:   morning_level_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_EVENING_LEVEL:   evening_level_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_EVENING_HOLD_MS: evening_hold_ff  <= csr_wdata;
            CSR_MORNING_HOLD_MS: morning_hold_ff  <= csr_wdata;
            CSR_STARTUP_WAIT_MS: startup_wait_ff  <= csr_wdata;
            CSR_STUCK_LIMIT_MS:  stuck_limit_ff   <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sensor_ff <= req_sensor_value;
         now_ff    <= req_now_ms;
      end
   end

   // Next phase and timer origin
   always_comb begin
      phase_in  = phase_ff;
      origin_in = origin_ff;
      unique case (phase_ff)
         PH_START: begin
            if (elapsed > startup_wait_ff) begin
               phase_in  = (sensor_ff > evening_level_ff) ? PH_DAY : PH_NIGHT;
               origin_in = now_ff;
            end
         end
         PH_DAY: begin
            // a fresh crossing restarts the timer, so it cannot also fail
            if (sensor_ff < evening_level_ff) begin
               phase_in  = PH_EVE;
               origin_in = now_ff;
            end else if (elapsed > stuck_limit_ff) begin
               phase_in  = PH_FAIL;
               origin_in = now_ff;
            end
         end
         PH_EVE: begin
            if (sensor_ff < evening_level_ff) begin
               if (elapsed > evening_hold_ff) begin
                  phase_in  = PH_NWORK;
                  origin_in = now_ff;
               end
            end else begin
               phase_in  = PH_DAY;
               origin_in = now_ff;
            end
         end
         PH_NWORK: begin
            phase_in = PH_NIGHT;
         end
         PH_NIGHT: begin
            if (sensor_ff > morning_level_ff) begin
               phase_in  = PH_MORN;
               origin_in = now_ff;
            end else if (elapsed > stuck_limit_ff) begin
               phase_in  = PH_FAIL;
               origin_in = now_ff;
            end
         end
         PH_MORN: begin
            // timer keeps running from the night crossing
            if (sensor_ff > morning_level_ff) begin
               if (elapsed > morning_hold_ff) begin
                  phase_in = PH_DWORK;
               end
            end else begin
               phase_in = PH_NIGHT;
            end
         end
         PH_DWORK: begin
            phase_in = PH_DAY;
         end
         PH_FAIL: begin
            phase_in = PH_FAIL;
         end
      endcase
   end

   // Pulses from the phase the item is taken in
   always_comb begin
      nw_pulse = (phase_ff == PH_NWORK);
      dw_pulse = (phase_ff == PH_DWORK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         origin_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         origin_ff <= origin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_phase_ff <= phase_in;
         rsp_nw_ff    <= nw_pulse;
         rsp_dw_ff    <= dw_pulse;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase_now        = rsp_phase_ff;
   assign rsp_night_work_pulse = rsp_nw_ff;
   assign rsp_day_work_pulse   = rsp_dw_ff;

`ifndef SYNTHESIS
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FAIL |=> phase_ff == PH_FAIL)
      else $error("fail phase left without reset");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_nw_ff && rsp_dw_ff))
      else $error("night and day work pulses together");

   a_night_pulse_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nw_ff |-> rsp_phase_ff == PH_NIGHT)
      else $error("night work pulse without entering night");

   a_day_pulse_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dw_ff |-> rsp_phase_ff == PH_DAY)
      else $error("day work pulse without entering day");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff && rsp_phase_ff == phase_ff)
      else $error("result phase differs from tracker phase");
`endif

endmodule
